/* sv/ddo_pkg.sv */
// Shared types, constants and microcode for the differential-drive odometry block.
// No dependencies; every other file but ddo_ifs.sv imports this package.
package ddo_pkg;

  localparam int unsigned ADDR_W = 4;

  typedef logic [3:0] step_t;
  typedef logic [4:0] iter_t;
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_LIN_GAIN = 2'd0;
  localparam reg_idx_t REG_ANG_GAIN = 2'd1;
  localparam reg_idx_t REG_START_X  = 2'd2;
  localparam reg_idx_t REG_START_Y  = 2'd3;

  localparam logic [31:0] LIN_GAIN_RST = 32'd353878;
  localparam logic [31:0] ANG_GAIN_RST = 32'd1083105;
  localparam logic [31:0] START_X_RST  = 32'hFFFD_199A;
  localparam logic [31:0] START_Y_RST  = 32'd0;

  localparam logic signed [10:0] SPEED_MAX  = 11'sd800;
  localparam logic signed [10:0] SPEED_MIN  = -11'sd800;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] QTURN_POS  = 32'sh4000_0000;
  localparam logic signed [31:0] QTURN_NEG  = 32'shC000_0000;
  localparam iter_t CORDIC_LAST = 5'd23;

  typedef enum logic [3:0] {
    OP_NOP, OP_TAKE, OP_FOLD, OP_ROT, OP_MUL_P, OP_NEG_P, OP_MUL_X, OP_ADD_X,
    OP_MUL_Y, OP_ADD_Y, OP_MUL_T, OP_ADD_T, OP_EMIT, OP_LOAD
  } dp_op_t;

  typedef enum logic [2:0] {
    JC_NEXT, JC_WAIT_ITEM, JC_LOAD, JC_LOOP, JC_WAIT_OUT, JC_GOTO
  } jmp_cond_t;

  typedef struct packed {
    dp_op_t    op;
    jmp_cond_t cond;
    step_t     target;
  } uword_t;

  typedef struct packed {
    logic take;
    logic load;
    logic iter_last;
    logic out_busy;
  } seq_stat_t;

  typedef struct packed {
    logic [31:0] lin_gain;
    logic [31:0] ang_gain;
    logic [31:0] start_x;
    logic [31:0] start_y;
  } cfg_regs_t;

  localparam step_t ST_IDLE  = 4'd0;
  localparam step_t ST_FOLD  = 4'd1;
  localparam step_t ST_ROT   = 4'd2;
  localparam step_t ST_MUL_P = 4'd3;
  localparam step_t ST_NEG_P = 4'd4;
  localparam step_t ST_MUL_X = 4'd5;
  localparam step_t ST_ADD_X = 4'd6;
  localparam step_t ST_MUL_Y = 4'd7;
  localparam step_t ST_ADD_Y = 4'd8;
  localparam step_t ST_MUL_T = 4'd9;
  localparam step_t ST_ADD_T = 4'd10;
  localparam step_t ST_EMIT  = 4'd11;
  localparam step_t ST_LOAD  = 4'd12;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{op: OP_NOP, cond: JC_GOTO, target: ST_IDLE};
    case (s)
      ST_IDLE:  w = '{op: OP_TAKE,  cond: JC_WAIT_ITEM, target: ST_FOLD};
      ST_FOLD:  w = '{op: OP_FOLD,  cond: JC_LOAD,      target: ST_LOAD};
      ST_ROT:   w = '{op: OP_ROT,   cond: JC_LOOP,      target: ST_ROT};
      ST_MUL_P: w = '{op: OP_MUL_P, cond: JC_NEXT,      target: ST_IDLE};
      ST_NEG_P: w = '{op: OP_NEG_P, cond: JC_NEXT,      target: ST_IDLE};
      ST_MUL_X: w = '{op: OP_MUL_X, cond: JC_NEXT,      target: ST_IDLE};
      ST_ADD_X: w = '{op: OP_ADD_X, cond: JC_NEXT,      target: ST_IDLE};
      ST_MUL_Y: w = '{op: OP_MUL_Y, cond: JC_NEXT,      target: ST_IDLE};
      ST_ADD_Y: w = '{op: OP_ADD_Y, cond: JC_NEXT,      target: ST_IDLE};
      ST_MUL_T: w = '{op: OP_MUL_T, cond: JC_NEXT,      target: ST_IDLE};
      ST_ADD_T: w = '{op: OP_ADD_T, cond: JC_NEXT,      target: ST_IDLE};
      ST_EMIT:  w = '{op: OP_EMIT,  cond: JC_WAIT_OUT,  target: ST_IDLE};
      ST_LOAD:  w = '{op: OP_LOAD,  cond: JC_GOTO,      target: ST_EMIT};
      default:  w = '{op: OP_NOP,   cond: JC_GOTO,      target: ST_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] atan_turn(iter_t i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [10:0] clamp_speed(logic signed [10:0] v);
    logic signed [10:0] r;
    r = v;
    if (v > SPEED_MAX) r = SPEED_MAX;
    if (v < SPEED_MIN) r = SPEED_MIN;
    return r;
  endfunction

endpackage

/* sv/ddo_ifs.sv */
// Valid/ready channel interfaces for the odometry input and result items.
// Depends on nothing; used by the top level and the datapath.
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [10:0] left_speed;
  logic signed [10:0] right_speed;

  modport source (output valid, action, left_speed, right_speed, input ready);
  modport sink   (input valid, action, left_speed, right_speed, output ready);
endinterface

interface ddo_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [15:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

/* sv/ddo_cfg.sv */
// APB-style register bank: linear and angular gains, start pose.
// Depends on ddo_pkg.
module ddo_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ddo_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ddo_pkg::cfg_regs_t         regs
);
  import ddo_pkg::*;

  cfg_regs_t regs_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign regs   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.lin_gain <= LIN_GAIN_RST;
      regs_r.ang_gain <= ANG_GAIN_RST;
      regs_r.start_x  <= START_X_RST;
      regs_r.start_y  <= START_Y_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_LIN_GAIN: regs_r.lin_gain <= pwdata;
        REG_ANG_GAIN: regs_r.ang_gain <= pwdata;
        REG_START_X:  regs_r.start_x  <= pwdata;
        REG_START_Y:  regs_r.start_y  <= pwdata;
        default:      regs_r.lin_gain <= regs_r.lin_gain;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LIN_GAIN: prdata = regs_r.lin_gain;
      REG_ANG_GAIN: prdata = regs_r.ang_gain;
      REG_START_X:  prdata = regs_r.start_x;
      REG_START_Y:  prdata = regs_r.start_y;
      default:      prdata = '0;
    endcase
  end

endmodule

/* sv/ddo_seq.sv */
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on ddo_pkg for the control word format and program.
module ddo_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ddo_pkg::seq_stat_t    stat,
  output ddo_pkg::dp_op_t       op
);
  import ddo_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;

  assign uw = ucode(step_r);
  assign op = uw.op;

  always_comb begin
    step_nxt = step_r + step_t'(1);
    unique case (uw.cond)
      JC_NEXT:      step_nxt = step_r + step_t'(1);
      JC_WAIT_ITEM: if (!stat.take) step_nxt = step_r;
      JC_LOAD:      if (stat.load) step_nxt = uw.target;
      JC_LOOP:      if (!stat.iter_last) step_nxt = uw.target;
      JC_WAIT_OUT:  step_nxt = stat.out_busy ? step_r : uw.target;
      JC_GOTO:      step_nxt = uw.target;
      default:      step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* sv/ddo_dp.sv */
// Odometry datapath: CORDIC registers, shared multiplier, pose state, result register.
// Depends on ddo_pkg and the channel interfaces; driven by ddo_seq.
module ddo_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  ddo_pkg::dp_op_t    op,
  input  ddo_pkg::cfg_regs_t regs,
  output ddo_pkg::seq_stat_t stat,
  ddo_in_if.sink             in_item,
  ddo_out_if.source          out_item
);
  import ddo_pkg::*;

  logic               act_r;
  logic signed [11:0] sum_r;
  logic signed [11:0] diff_r;
  logic signed [31:0] x_r;
  logic signed [31:0] y_r;
  logic signed [31:0] z_r;
  logic               flip_r;
  iter_t              iter_r;
  logic signed [64:0] prod_r;
  logic signed [28:0] negp_r;
  logic [31:0]        pos_x_r;
  logic [31:0]        pos_y_r;
  logic [31:0]        head_r;
  logic               out_valid_r;
  logic [31:0]        out_x_r;
  logic [31:0]        out_y_r;
  logic [15:0]        out_h_r;

  logic signed [10:0] l_clamp;
  logic signed [10:0] r_clamp;
  logic signed [31:0] z0;
  logic               fold;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] sin_v;
  logic signed [31:0] cos_v;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod;
  logic signed [27:0] p_w;
  logic               take;
  logic               emit;

  assign in_item.ready = (op == OP_TAKE) && rst_n;
  assign take          = in_item.valid && in_item.ready;
  assign l_clamp       = clamp_speed(in_item.left_speed);
  assign r_clamp       = clamp_speed(in_item.right_speed);

  assign z0   = $signed(head_r);
  assign fold = (z0 > QTURN_POS) || (z0 < QTURN_NEG);
  assign xs   = x_r >>> iter_r;
  assign ys   = y_r >>> iter_r;
  assign sin_v = flip_r ? -y_r : y_r;
  assign cos_v = flip_r ? -x_r : x_r;
  assign p_w   = $signed(prod_r[43:16]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_MUL_P: begin
        mul_a = $signed({1'b0, regs.lin_gain});
        mul_b = 32'(sum_r);
      end
      OP_MUL_X: begin
        mul_a = 33'(negp_r);
        mul_b = sin_v;
      end
      OP_MUL_Y: begin
        mul_a = 33'(negp_r);
        mul_b = cos_v;
      end
      OP_MUL_T: begin
        mul_a = $signed({1'b0, regs.ang_gain});
        mul_b = 32'(diff_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign emit = (op == OP_EMIT) && !stat.out_busy;

  assign stat.take      = take;
  assign stat.load      = act_r;
  assign stat.iter_last = (iter_r == CORDIC_LAST);
  assign stat.out_busy  = out_valid_r && !out_item.ready;

  always_ff @(posedge clk) begin
    if (take) begin
      act_r  <= in_item.action;
      sum_r  <= 12'(l_clamp) + 12'(r_clamp);
      diff_r <= 12'(r_clamp) - 12'(l_clamp);
    end
    case (op)
      OP_FOLD: begin
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= fold ? {~z0[31], z0[30:0]} : z0;
        flip_r <= fold;
        iter_r <= '0;
      end
      OP_ROT: begin
        if (!z_r[31]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - $signed(atan_turn(iter_r));
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + $signed(atan_turn(iter_r));
        end
        iter_r <= iter_r + iter_t'(1);
      end
      OP_MUL_P, OP_MUL_X, OP_MUL_Y, OP_MUL_T: prod_r <= prod;
      OP_NEG_P: negp_r <= -29'(p_w);
      default: negp_r <= negp_r;
    endcase
    if (emit) begin
      out_x_r <= pos_x_r;
      out_y_r <= pos_y_r;
      out_h_r <= head_r[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (op)
        OP_ADD_X: pos_x_r <= pos_x_r + prod_r[62:31];
        OP_ADD_Y: pos_y_r <= pos_y_r + prod_r[62:31];
        OP_ADD_T: head_r  <= head_r + prod_r[31:0];
        OP_LOAD: begin
          pos_x_r <= regs.start_x;
          pos_y_r <= regs.start_y;
          head_r  <= '0;
        end
        default: head_r <= head_r;
      endcase
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_item.valid   = out_valid_r;
  assign out_item.pos_x   = out_x_r;
  assign out_item.pos_y   = out_y_r;
  assign out_item.heading = out_h_r;

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !in_item.ready)
    else $error("second item taken while one is at work");

  a_rot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_ROT) |-> (iter_r <= CORDIC_LAST))
    else $error("CORDIC iteration index past last step");

  a_load_clears_heading: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_LOAD) |=> (head_r == '0))
    else $error("load did not clear heading");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(op == OP_EMIT))
    else $error("result raised outside the emit step");

endmodule

/* sv/differential_drive_odometry_top.sv */
// Channel   Dir  Handshake        Payload
// in_item   in   valid/ready      action, left_speed, right_speed
// out_item  out  valid/ready      pos_x, pos_y, heading
// apb       in   psel/penable     paddr[3:2] selects gain or start register
//
// Advance item, from accept to result: take, fold, 24 CORDIC steps, 8
// multiply/accumulate steps on the one shared multiplier, emit. Load item:
// take, fold, load, emit. The next item is accepted once the sequencer is back
// at its idle step; a result waiting in the output register stalls only emit.
// rst_n is synchronous; pose and heading reset to zero, registers to defaults.
module differential_drive_odometry_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ddo_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  ddo_in_if.sink                     in_item,
  ddo_out_if.source                  out_item
);
  import ddo_pkg::*;

  cfg_regs_t regs;
  seq_stat_t stat;
  dp_op_t    op;

  ddo_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  ddo_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  ddo_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .regs     (regs),
    .stat     (stat),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

/* sim/differential_drive_odometry_top_tb.sv */
// Self-checking bench for differential_drive_odometry_top: random and directed wheel items,
// APB register phases, and a pose predictor including the CORDIC sine/cosine.
// Depends on ddo_pkg, ddo_in_if/ddo_out_if and the top level.
module differential_drive_odometry_top_tb;
  import ddo_pkg::*;

  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;
  localparam longint SPEED_LIM = 800;
  localparam longint CORDIC_X0 = 652032874;
  localparam int CORDIC_ROUNDS = 24;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 40;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SHOWN_FAULTS  = 10;

  typedef struct packed {
    logic               action;
    logic signed [10:0] left_spd;
    logic signed [10:0] right_spd;
  } move_t;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
  } pose_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  ddo_in_if  in_ch ();
  ddo_out_if out_ch ();

  differential_drive_odometry_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  int unsigned atan_tbl [0:CORDIC_ROUNDS-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81
  };

  logic [31:0] lin_gain;
  logic [31:0] ang_gain;
  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [31:0] cur_x;
  logic [31:0] cur_y;
  logic [31:0] cur_heading;

  move_t move_backlog [$];
  pose_t pose_queue [$];
  move_t next_move;
  move_t seen_move;
  pose_t want_pose;

  int  moves_queued;
  int  moves_taken;
  bit  move_taken;
  int  fault_count;
  int  send_idle_pct;
  int  take_idle_pct;
  int  hold_asked;
  int  hold_done;
  int  hold_left;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint limit_speed(logic signed [10:0] s);
    longint v;
    v = s;
    if (v > SPEED_LIM) v = SPEED_LIM;
    if (v < -SPEED_LIM) v = -SPEED_LIM;
    return v;
  endfunction

  function automatic void turn_to_sin_cos(input logic [31:0] angle, output longint sn,
                                          output longint cs);
    longint z;
    longint x;
    longint y;
    longint t;
    bit     flip;
    int     k;
    z = longint'($signed(angle));
    flip = 1'b0;
    if (z > 64'sd1073741824) begin
      z = z - 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z = z + 64'sd2147483648;
      flip = 1'b1;
    end
    x = CORDIC_X0;
    y = 0;
    for (k = 0; k < CORDIC_ROUNDS; k++) begin
      if (z >= 0) begin
        t = x - (y >>> k);
        y = y + (x >>> k);
        z = z - longint'({32'd0, atan_tbl[k]});
      end else begin
        t = x + (y >>> k);
        y = y - (x >>> k);
        z = z + longint'({32'd0, atan_tbl[k]});
      end
      x = t;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic pose_t odometry_step(move_t m);
    longint lft;
    longint rgt;
    longint sn;
    longint cs;
    longint p;
    longint dx;
    longint dy;
    longint turn;
    pose_t  r;
    if (m.action == ACT_LOAD) begin
      cur_x = start_x;
      cur_y = start_y;
      cur_heading = '0;
    end else begin
      lft = limit_speed(m.left_spd);
      rgt = limit_speed(m.right_spd);
      turn_to_sin_cos(cur_heading, sn, cs);
      p = (longint'({32'd0, lin_gain}) * (lft + rgt)) >>> 16;
      dx = (-p * sn) >>> 31;
      dy = (-p * cs) >>> 31;
      cur_x = cur_x + dx[31:0];
      cur_y = cur_y + dy[31:0];
      turn = longint'({32'd0, ang_gain}) * (rgt - lft);
      cur_heading = cur_heading + turn[31:0];
    end
    r.pos_x = cur_x;
    r.pos_y = cur_y;
    r.heading = cur_heading[31:16];
    return r;
  endfunction

  function automatic void note_fault(string what, logic [31:0] want, logic [31:0] got);
    if (fault_count < SHOWN_FAULTS)
      $display("mismatch on %s after %0d items: expected %h, got %h", what, moves_taken,
               want, got);
    fault_count++;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || move_taken) begin
      move_taken = 1'b0;
      if (move_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_move = move_backlog.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= next_move.action;
        in_ch.left_speed <= next_move.left_spd;
        in_ch.right_speed <= next_move.right_spd;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done <= hold_asked;
      hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pose_queue.size() == 0) begin
          note_fault("unexpected result pos_x", '0, out_ch.pos_x);
        end else begin
          want_pose = pose_queue.pop_front();
          if (out_ch.pos_x !== want_pose.pos_x)
            note_fault("pos_x", want_pose.pos_x, out_ch.pos_x);
          if (out_ch.pos_y !== want_pose.pos_y)
            note_fault("pos_y", want_pose.pos_y, out_ch.pos_y);
          if (out_ch.heading !== want_pose.heading)
            note_fault("heading", {16'd0, want_pose.heading}, {16'd0, out_ch.heading});
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_move.action = in_ch.action;
        seen_move.left_spd = in_ch.left_speed;
        seen_move.right_spd = in_ch.right_speed;
        pose_queue.push_back(odometry_step(seen_move));
        moves_taken++;
        move_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LIN_GAIN: lin_gain = val;
      REG_ANG_GAIN: ang_gain = val;
      REG_START_X:  start_x = val;
      default:      start_y = val;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] lg, input logic [31:0] ag,
                           input logic [31:0] sx, input logic [31:0] sy);
    write_reg(REG_LIN_GAIN, lg);
    write_reg(REG_ANG_GAIN, ag);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
  endtask

  task automatic queue_move(input logic act, input int lft, input int rgt);
    move_t m;
    m.action = act;
    m.left_spd = lft[10:0];
    m.right_spd = rgt[10:0];
    move_backlog.push_back(m);
    moves_queued++;
  endtask

  task automatic queue_random(input int count, input int load_pct);
    int n;
    int lft;
    int rgt;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20) begin
        lft = $urandom_range(2047) - 1024;
        rgt = $urandom_range(2047) - 1024;
      end else begin
        lft = $urandom_range(1600) - 800;
        rgt = $urandom_range(1600) - 800;
      end
      queue_move(($urandom_range(99) < load_pct) ? ACT_LOAD : ACT_ADVANCE, lft, rgt);
    end
  endtask

  task automatic settle();
    while (move_backlog.size() != 0 || moves_taken != moves_queued || pose_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_ADVANCE;
    in_ch.left_speed = '0;
    in_ch.right_speed = '0;
    out_ch.ready = 1'b0;
    lin_gain = LIN_GAIN_RST;
    ang_gain = ANG_GAIN_RST;
    start_x = START_X_RST;
    start_y = START_Y_RST;
    cur_x = '0;
    cur_y = '0;
    cur_heading = '0;
    moves_queued = 0;
    moves_taken = 0;
    move_taken = 1'b0;
    fault_count = 0;
    send_idle_pct = 33;
    take_idle_pct = 33;
    hold_asked = 0;
    hold_done = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_move(ACT_ADVANCE, 0, 0);
    queue_move(ACT_ADVANCE, 800, 800);
    queue_move(ACT_ADVANCE, -800, -800);
    queue_move(ACT_ADVANCE, 800, -800);
    queue_move(ACT_ADVANCE, -800, 800);
    queue_move(ACT_ADVANCE, 1023, 1023);
    queue_move(ACT_ADVANCE, -1024, -1024);
    queue_move(ACT_ADVANCE, 801, -801);
    queue_move(ACT_LOAD, 1023, -1024);
    queue_move(ACT_ADVANCE, 300, 500);
    queue_move(ACT_ADVANCE, -1, 1);
    repeat (3) queue_move(ACT_ADVANCE, 800, -800);
    repeat (4) queue_move(ACT_ADVANCE, -800, 800);
    queue_move(ACT_ADVANCE, 800, 0);
    queue_move(ACT_LOAD, 0, 0);
    queue_move(ACT_ADVANCE, 0, 800);
    settle();

    queue_random(150, 5);
    settle();

    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_move(ACT_LOAD, 0, 0);
    queue_random(100, 3);
    settle();

    write_all(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_move(ACT_LOAD, -1024, 1023);
    queue_random(50, 5);
    settle();

    write_all($urandom, $urandom, $urandom, $urandom);
    send_idle_pct = 0;
    take_idle_pct = 0;
    queue_random(120, 4);
    settle();

    write_all(LIN_GAIN_RST, ANG_GAIN_RST, START_X_RST, START_Y_RST);
    take_idle_pct = 33;
    queue_random(60, 4);
    hold_asked++;
    settle();

    send_idle_pct = 33;
    for (ph = 0; ph < 4; ph++) begin
      write_all($urandom_range(32'h00FF_FFFF), $urandom, $urandom, $urandom);
      queue_move(ACT_LOAD, 0, 0);
      queue_random(80, 5);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pose_queue.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
